/* src/b58e_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block base58 encoder package
// Payload types, job type, digit tables and the divide-by-58 step.
// ----------------------------------------------------------------------------
package b58e_pkg;

   localparam int BLOCK_BYTES  = 8;
   localparam int BLOCK_DIGITS = 11;
   localparam int RADIX        = 58;
   localparam int CHUNK_BITS   = 16;
   localparam int CHUNK_COUNT  = 64 / CHUNK_BITS;

   localparam logic [1:0] CHUNK_TOP = 2'(CHUNK_COUNT - 1);

   // Reciprocal of 29 for an exact floor division of a 21-bit value.
   localparam logic [21:0] RECIP_29  = 22'd2314099;
   localparam int          RECIP_SHIFT = 26;

   localparam logic [58*8-1:0] ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   // Characters emitted for a block of n bytes, indexed by n.
   localparam logic [8:0][3:0] DIGITS_FOR_BYTES = {
      4'd11, 4'd10, 4'd9, 4'd7, 4'd6, 4'd5, 4'd3, 4'd2, 4'd0
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       end_of_text;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] block_value;
      logic [3:0]  digit_count;
      logic        is_last;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   // Quotient of x / 58 for x below 58 * 2^16. Halving first leaves a
   // division by 29, which the reciprocal covers exactly.
   function automatic logic [15:0] div58_quot(input logic [21:0] x);
      logic [42:0] prod;
      prod = {1'b0, x[21:1]} * {21'd0, RECIP_29};
      return prod[RECIP_SHIFT +: 16];
   endfunction

   // The remainder is below 64, so only the low six bits are needed.
   function automatic logic [5:0] div58_rem(input logic [21:0] x,
                                            input logic [15:0] q);
      logic [11:0] back;
      back = {6'd0, q[5:0]} * 12'(RADIX);
      return x[5:0] - back[5:0];
   endfunction

   function automatic logic [6:0] base58_char(input logic [5:0] digit);
      logic [7:0] code;
      if (digit < 6'(RADIX)) begin
         code = ALPHABET[(6'(RADIX - 1) - digit) * 8 +: 8];
      end else begin
         code = ALPHABET[(RADIX - 1) * 8 +: 8];
      end
      return code[6:0];
   endfunction

endpackage

/* src/b58e_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block base58 encoder front end
// Packs request bytes big-endian into a block and hands each finished or
// final block to the job queue with its character count.
// ----------------------------------------------------------------------------
module b58e_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  b58e_pkg::req_payload_type req_payload,
   output logic                     push_valid,
   input  logic                     push_ready,
   output b58e_pkg::job_type        push_job
);
   import b58e_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [2:0]  held_ff, held_in;
   logic [3:0]  held_next;
   logic [63:0] value_next;
   logic        block_done;

   assign held_next  = {1'b0, held_ff} + 4'd1;
   assign value_next = {acc_ff[55:0], req_payload.data_byte};
   assign block_done = (held_next == 4'(BLOCK_BYTES)) || req_payload.is_final;

   assign req_ready  = push_ready;
   assign push_valid = req_valid && block_done;

   always_comb begin
      push_job.block_value = value_next;
      push_job.digit_count = DIGITS_FOR_BYTES[held_next];
      push_job.is_last     = req_payload.is_final;
   end

   always_comb begin
      acc_in  = acc_ff;
      held_in = held_ff;
      if (req_valid && req_ready) begin
         if (block_done) begin
            acc_in  = '0;
            held_in = '0;
         end else begin
            acc_in  = value_next;
            held_in = held_next[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

endmodule

/* src/b58e_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block base58 encoder job queue
// Two-entry queue that lets the front end collect the next block while
// the back end is still converting the previous one.
// ----------------------------------------------------------------------------
module b58e_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  b58e_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output b58e_pkg::job_type pop_job
);
   import b58e_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue occupancy beyond two entries");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");

endmodule

/* src/b58e_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block base58 encoder back end
// Divides each block by 58 one 16-bit chunk per cycle, stores the digits
// and then sends them most significant first as alphabet characters.
// ----------------------------------------------------------------------------
module b58e_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  b58e_pkg::job_type         pop_job,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output b58e_pkg::rsp_payload_type rsp_payload
);
   import b58e_pkg::*;

   back_state_type  state_ff, state_in;
   logic [63:0]     quot_ff, quot_in;
   logic [5:0]      rem_ff, rem_in;
   logic [1:0]      chunk_ff, chunk_in;
   logic [3:0]      dig_idx_ff, dig_idx_in;
   logic [3:0]      rd_idx_ff, rd_idx_in;
   logic [3:0]      ndig_ff, ndig_in;
   logic            last_ff, last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [5:0]      digit_ff [BLOCK_DIGITS];
   logic            digit_we;

   logic [21:0]     step_x;
   logic [15:0]     step_quot;
   logic [5:0]      step_rem;

   assign step_x    = {rem_ff, quot_ff[chunk_ff * CHUNK_BITS +: CHUNK_BITS]};
   assign step_quot = div58_quot(step_x);
   assign step_rem  = div58_rem(step_x, step_quot);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      chunk_in       = chunk_ff;
      dig_idx_in     = dig_idx_ff;
      rd_idx_in      = rd_idx_ff;
      ndig_in        = ndig_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      digit_we       = 1'b0;
      pop_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               quot_in    = pop_job.block_value;
               ndig_in    = pop_job.digit_count;
               last_in    = pop_job.is_last;
               dig_idx_in = pop_job.digit_count - 4'd1;
               rem_in     = '0;
               chunk_in   = CHUNK_TOP;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            // The quotient replaces the chunk in place, so the next digit
            // starts from the updated value.
            quot_in[chunk_ff * CHUNK_BITS +: CHUNK_BITS] = step_quot;
            rem_in   = step_rem;
            chunk_in = chunk_ff - 2'd1;
            if (chunk_ff == 2'd0) begin
               digit_we = 1'b1;
               rem_in   = '0;
               if (dig_idx_ff == 4'd0) begin
                  rd_idx_in = '0;
                  state_in  = ST_EMIT;
               end else begin
                  dig_idx_in = dig_idx_ff - 4'd1;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.char_code   = base58_char(digit_ff[rd_idx_ff]);
               rsp_payload_in.end_of_text = last_ff && (rd_idx_ff == ndig_ff - 4'd1);
               rd_idx_in                  = rd_idx_ff + 4'd1;
               if (rd_idx_ff == ndig_ff - 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_ff[dig_idx_ff] <= step_rem;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff        <= quot_in;
      rem_ff         <= rem_in;
      chunk_ff       <= chunk_in;
      dig_idx_ff     <= dig_idx_in;
      rd_idx_ff      <= rd_idx_in;
      ndig_ff        <= ndig_in;
      last_ff        <= last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < 6'(RADIX)))
      else $error("partial remainder not below the radix");

   a_div_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dig_idx_ff < ndig_ff && ndig_ff <= 4'(BLOCK_DIGITS)))
      else $error("digit write index outside the block");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rd_idx_ff < ndig_ff))
      else $error("digit read index outside the block");

   a_eot_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_in && (!rsp_valid_ff || rsp_ready)
       && rsp_payload_in.end_of_text) |=> (state_ff == ST_IDLE))
      else $error("end of text sent before the last digit");

endmodule

/* src/block_base58_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block base58 encoder
// Encodes a byte stream in 8-byte blocks into base58 characters, most
// significant digit first, marking the final character of the message.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    data_byte[7:0], is_final
//   rsp_      out        rsp_valid/rsp_ready    char_code[6:0], end_of_text
//
// A byte that does not close a block is taken while the job queue has room.
// For each digit of a block the back end runs the shared divide-by-58 unit
// (16 bits per cycle) over every chunk of the block, then sends the
// characters once all digits are stored.
// A two-entry job queue lets bytes keep arriving while a block converts.
// Reset is synchronous and active high; a stalled result holds in the
// output register while the back end starts the next block.
// ----------------------------------------------------------------------------
module block_base58_encoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  b58e_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output b58e_pkg::rsp_payload_type rsp_payload
);
   import b58e_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   b58e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   b58e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   b58e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block base58 encoder testbench
// Feeds byte messages through the request channel and checks every character
// against a block-wise base58 predictor, with sender bursts, receiver stall
// patterns and one long output hold that backs the block up to its input.
// ----------------------------------------------------------------------------
module tb_top;
   import b58e_pkg::*;

   typedef enum int {
      READY_OPEN,
      READY_RANDOM,
      READY_PERIODIC
   } ready_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   string           char_set = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   // Predictor state: the partial block and the number of bytes in it.
   logic [63:0]     block_acc = '0;
   int              held_count = 0;
   rsp_payload_type expected_chars[$];
   rsp_payload_type want;

   int              fail_count = 0;
   int              bytes_sent = 0;
   int              burst_left = 0;
   int              long_hold = 0;
   int              ready_phase = 0;
   ready_mode_type  ready_mode = READY_OPEN;

   block_base58_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int chars_for_length(input int n);
      case (n)
         1: return 2;
         2: return 3;
         3: return 5;
         4: return 6;
         5: return 7;
         6: return 9;
         7: return 10;
         default: return 11;
      endcase
   endfunction

   // Folds one accepted request into the block and queues the characters
   // that it releases, most significant digit first.
   function automatic void predict_chars(input req_payload_type p);
      logic [63:0]     num;
      logic [5:0]      digits[11];
      int              count;
      int              i;
      rsp_payload_type c;
      block_acc = {block_acc[55:0], p.data_byte};
      held_count = held_count + 1;
      if (held_count == BLOCK_BYTES) begin
         count = BLOCK_DIGITS;
      end else if (p.is_final) begin
         count = chars_for_length(held_count);
      end else begin
         return;
      end
      num = block_acc;
      for (i = count - 1; i >= 0; i--) begin
         digits[i] = 6'(num % 64'd58);
         num = num / 64'd58;
      end
      for (i = 0; i < count; i++) begin
         c.char_code = 7'(char_set[digits[i]]);
         c.end_of_text = p.is_final && (i == count - 1);
         expected_chars.push_back(c);
      end
      block_acc = '0;
      held_count = 0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_payload <= '{data_byte: b, is_final: fin};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_chars('{data_byte: b, is_final: fin});
      bytes_sent++;
   endtask

   task automatic idle(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Bursts of random length; some bursts follow each other without a gap.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_message(input int len, input bit paced);
      int i;
      for (i = 0; i < len; i++) begin
         send_byte(pick_byte(), i == len - 1);
         if (paced) begin
            pace();
         end
      end
   endtask

   // Receiver: a long hold when one is asked for, otherwise the current mode.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (long_hold > 0) begin
            rsp_ready <= 1'b0;
            long_hold--;
         end else begin
            case (ready_mode)
               READY_OPEN: rsp_ready <= 1'b1;
               READY_RANDOM: rsp_ready <= ($urandom_range(0, 99) >= 35);
               default: begin
                  ready_phase = (ready_phase + 1) % 7;
                  rsp_ready <= (ready_phase < 4);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("char_code: expected none, got %0d", rsp_payload.char_code);
            fail_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.char_code !== want.char_code) begin
               $error("char_code: expected %0d, got %0d", want.char_code,
                      rsp_payload.char_code);
               fail_count++;
            end
            if (rsp_payload.end_of_text !== want.end_of_text) begin
               $error("end_of_text: expected %0d, got %0d", want.end_of_text,
                      rsp_payload.end_of_text);
               fail_count++;
            end
         end
      end
   end

   // Single bytes at both extremes, full blocks of ones and zeros, and a
   // partial block that follows a full block inside one message.
   task automatic test_directed_blocks();
      int i;
      ready_mode = READY_OPEN;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      for (i = 0; i < 8; i++) begin
         send_byte(8'hFF, i == 7);
      end
      for (i = 0; i < 8; i++) begin
         send_byte(8'h00, 1'b0);
      end
      for (i = 0; i < 7; i++) begin
         send_byte(8'h80 + 8'(i * 21), i == 6);
      end
      idle(3);
   endtask

   task automatic test_random_messages(input int count);
      int stop_at;
      ready_mode = READY_RANDOM;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         send_message($urandom_range(1, 20), 1'b1);
      end
   endtask

   task automatic test_periodic_stall(input int count);
      int stop_at;
      ready_mode = READY_PERIODIC;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         send_message($urandom_range(1, 12), 1'b1);
      end
   endtask

   // The receiver holds off while full blocks keep arriving back to back.
   task automatic test_output_hold();
      int i;
      ready_mode = READY_OPEN;
      long_hold = 600;
      for (i = 0; i < 6; i++) begin
         send_message(8, 1'b0);
      end
      idle(1);
   endtask

   task automatic finish_run();
      int waited;
      idle(1);
      waited = 0;
      while (expected_chars.size() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (expected_chars.size() > 0) begin
         $error("end_of_text: %0d characters never arrived", expected_chars.size());
         fail_count++;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_blocks();
      test_random_messages(155);
      test_periodic_stall(70);
      test_output_hold();
      finish_run();
      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
